// File: src/escc_pkg.sv
// escc_pkg: shared types, constants and calendar tables for the converter
// used by escc_ctrl, escc_dpath and epoch_seconds_calendar_converter_core
`timescale 1ns / 1ps

package escc_pkg;

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;
  localparam logic [16:0] DAYS_PER_WEEK = 17'd7;
  localparam logic [31:0] DAYS_IN_RANGE = 32'd36525;
  localparam logic [15:0] WEEKDAY_BIAS  = 16'd6;
  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
  localparam logic [3:0]  LAST_MONTH    = 4'd12;
  localparam logic [3:0]  FEBRUARY      = 4'd2;

  // reciprocals for divide by multiply: q = ((x >> pre) * m) >> post,
  // exact over each operand range (day: 25-bit, hour: 13-bit, minute: 10-bit, week: 16-bit)
  localparam logic [25:0] RECIP_DAY  = 26'd50903317;
  localparam logic [25:0] RECIP_HOUR = 26'd9321;
  localparam logic [25:0] RECIP_MIN  = 26'd1093;
  localparam logic [25:0] RECIP_WEEK = 26'd74899;

  // divider jobs
  typedef enum logic [1:0] {
    JOB_DAY,
    JOB_HOUR,
    JOB_MIN,
    JOB_WEEK
  } job_t;

  // date to seconds steps
  typedef enum logic [2:0] {
    CV_IDLE,
    CV_DAYS,
    CV_HOURS,
    CV_MINS,
    CV_SECS
  } conv_t;

  typedef struct packed {
    logic  load;
    logic  div_start;
    job_t  div_job;
    conv_t conv_op;
    logic  year_step;
    logic  month_step;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic div_done;
    logic year_fit;
    logic month_fit;
    logic oor;
  } stat_t;

  // length of a common-year month, months 1 to 12
  function automatic logic [4:0] month_len(input logic [3:0] mo);
    logic [4:0] len;
    case (mo)
      4'd2:    len = 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // days of the common-year months before mo; none for 0 or 1, a whole year past 12
  function automatic logic [8:0] days_before(input logic [3:0] mo);
    logic [8:0] d;
    case (mo)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd365;
    endcase
    return d;
  endfunction

endpackage

// File: src/escc_ctrl.sv
// escc_ctrl: sequencing state machine of the converter
// depends on escc_pkg for command and status types
`timescale 1ns / 1ps

module escc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  escc_pkg::stat_t stat,
  output escc_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_CV_DAYS,
    S_CV_HOURS,
    S_CV_MINS,
    S_CV_SECS,
    S_DSTART,
    S_DWAIT,
    S_YEAR,
    S_MONTH,
    S_FINISH
  } state_t;

  state_t        state;
  escc_pkg::job_t job;
  logic          out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd            = '0;
    cmd.div_job    = job;
    cmd.conv_op    = escc_pkg::CV_IDLE;
    cmd.load       = (state == S_IDLE) && in_valid;
    cmd.div_start  = (state == S_DSTART);
    cmd.year_step  = (state == S_YEAR);
    cmd.month_step = (state == S_MONTH);
    cmd.out_load   = (state == S_FINISH) && out_free;
    case (state)
      S_CV_DAYS:  cmd.conv_op = escc_pkg::CV_DAYS;
      S_CV_HOURS: cmd.conv_op = escc_pkg::CV_HOURS;
      S_CV_MINS:  cmd.conv_op = escc_pkg::CV_MINS;
      S_CV_SECS:  cmd.conv_op = escc_pkg::CV_SECS;
      default:    cmd.conv_op = escc_pkg::CV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      job       <= escc_pkg::JOB_DAY;
      out_valid <= 1'b0;
    end else begin
      // a new result replaces the one taken in the same cycle
      if ((state == S_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            job   <= escc_pkg::JOB_DAY;
            state <= S_SETUP;
          end
        end
        S_SETUP:    state <= stat.kind ? S_CV_DAYS : S_DSTART;
        S_CV_DAYS:  state <= S_CV_HOURS;
        S_CV_HOURS: state <= S_CV_MINS;
        S_CV_MINS:  state <= S_CV_SECS;
        S_CV_SECS:  state <= S_DSTART;
        S_DSTART:   state <= S_DWAIT;
        S_DWAIT: begin
          if (stat.div_done) begin
            case (job)
              escc_pkg::JOB_DAY: begin
                job   <= stat.kind ? escc_pkg::JOB_WEEK : escc_pkg::JOB_HOUR;
                state <= S_DSTART;
              end
              escc_pkg::JOB_HOUR: begin
                job   <= escc_pkg::JOB_MIN;
                state <= S_DSTART;
              end
              escc_pkg::JOB_MIN: begin
                if (stat.oor) begin
                  state <= S_FINISH;
                end else begin
                  job   <= escc_pkg::JOB_WEEK;
                  state <= S_DSTART;
                end
              end
              escc_pkg::JOB_WEEK: state <= stat.kind ? S_FINISH : S_YEAR;
              default:            state <= S_FINISH;
            endcase
          end
        end
        S_YEAR:  if (stat.year_fit) state <= S_MONTH;
        S_MONTH: if (stat.month_fit) state <= S_FINISH;
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/escc_dpath.sv
// escc_dpath: operand registers, reciprocal divider, year and month walk, result register
// depends on escc_pkg for tables, constants and command and status types
`timescale 1ns / 1ps

module escc_dpath (
  input  logic            clk,
  input  logic            rst,
  input  escc_pkg::cmd_t  cmd,
  output escc_pkg::stat_t stat,
  input  logic            kind,
  input  logic [31:0]     seconds_in,
  input  logic [6:0]      year_offset,
  input  logic [3:0]      month,
  input  logic [4:0]      day,
  input  logic [4:0]      hour,
  input  logic [5:0]      minute,
  input  logic [5:0]      second,
  output logic [31:0]     seconds_out,
  output logic [6:0]      year_offset_out,
  output logic [3:0]      month_out,
  output logic [4:0]      day_out,
  output logic [4:0]      hour_out,
  output logic [5:0]      minute_out,
  output logic [5:0]      second_out,
  output logic [2:0]      weekday,
  output logic            out_of_range
);

  // captured request
  logic        kind_r;
  logic [6:0]  y_r;
  logic [3:0]  mon_r;
  logic [4:0]  dy_r;
  logic [4:0]  hr_r;
  logic [5:0]  mi_r;
  logic [5:0]  sc_r;

  // working values
  logic [31:0] cnt;
  logic [31:0] acc;
  logic [15:0] days;
  logic [16:0] rem;
  logic [6:0]  yo;
  logic [3:0]  mo;
  logic [4:0]  hr_q;
  logic [5:0]  mi_q;
  logic [5:0]  sc_q;
  logic [2:0]  wd_q;
  logic        oor;

  // reciprocal divider: multiply, then quotient times divisor, then remainder
  logic [31:0]    dvd;
  logic [16:0]    dsor;
  escc_pkg::job_t djob;
  logic [1:0]     dph;
  logic           dbusy;
  logic           ddone;
  logic [24:0]    dmul_a;
  logic [25:0]    dmul_b;
  logic [50:0]    dprod;
  logic [15:0]    dquo;
  logic [15:0]    dq;
  logic [31:0]    dqd;
  logic [16:0]    drem;
  logic [31:0]    dividend;
  logic [16:0]    divisor;

  // calendar walk
  logic        leap;
  logic [9:0]  year_len;
  logic [5:0]  mlen;
  logic        year_fit;
  logic        month_fit;
  logic        leap_cv;
  logic [15:0] days_calc;

  always_comb begin
    case (cmd.div_job)
      escc_pkg::JOB_DAY: begin
        dividend = cnt;
        divisor  = escc_pkg::SECS_PER_DAY;
      end
      escc_pkg::JOB_HOUR: begin
        dividend = {15'd0, rem};
        divisor  = escc_pkg::SECS_PER_HOUR;
      end
      escc_pkg::JOB_MIN: begin
        dividend = {15'd0, rem};
        divisor  = escc_pkg::SECS_PER_MIN;
      end
      default: begin
        dividend = {16'd0, days + escc_pkg::WEEKDAY_BIAS};
        divisor  = escc_pkg::DAYS_PER_WEEK;
      end
    endcase
  end

  // low zero bits of the divisor shifted off first, then one reciprocal multiply
  always_comb begin
    case (djob)
      escc_pkg::JOB_DAY: begin
        dmul_a = dvd[31:7];
        dmul_b = escc_pkg::RECIP_DAY;
        dquo   = dprod[50:35];
      end
      escc_pkg::JOB_HOUR: begin
        dmul_a = {12'd0, dvd[16:4]};
        dmul_b = escc_pkg::RECIP_HOUR;
        dquo   = dprod[36:21];
      end
      escc_pkg::JOB_MIN: begin
        dmul_a = {10'd0, dvd[16:2]};
        dmul_b = escc_pkg::RECIP_MIN;
        dquo   = dprod[29:14];
      end
      default: begin
        dmul_a = {9'd0, dvd[15:0]};
        dmul_b = escc_pkg::RECIP_WEEK;
        dquo   = dprod[34:19];
      end
    endcase
  end

  // remainder is below the divisor, so 17 bits hold it
  assign drem = 17'(dvd - dqd);

  assign leap      = (yo[1:0] == 2'd0);
  assign year_len  = {1'b0, escc_pkg::DAYS_PER_YEAR} + {9'd0, leap};
  assign mlen      = {1'b0, escc_pkg::month_len(mo)}
                   + {5'd0, leap && (mo == escc_pkg::FEBRUARY)};
  assign year_fit  = days < {6'd0, year_len};
  assign month_fit = (mo == escc_pkg::LAST_MONTH) || (days < {10'd0, mlen});

  assign leap_cv   = (mon_r > escc_pkg::FEBRUARY) && (y_r[1:0] == 2'd0);
  // one more than the day number, as the final step takes a day off
  assign days_calc = {11'd0, dy_r} + {7'd0, escc_pkg::days_before(mon_r)}
                   + {15'd0, leap_cv}
                   + 16'({9'd0, y_r} * {7'd0, escc_pkg::DAYS_PER_YEAR})
                   + {10'd0, 6'(({1'b0, y_r} + 8'd3) >> 2)};

  assign stat.kind      = kind_r;
  assign stat.div_done  = ddone;
  assign stat.year_fit  = year_fit;
  assign stat.month_fit = month_fit;
  assign stat.oor       = oor;

  // divider control, three phases per job
  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      ddone <= 1'b0;
      dph   <= 2'd0;
    end else begin
      ddone <= dbusy && (dph == 2'd2);
      if (cmd.div_start) begin
        dbusy <= 1'b1;
        dph   <= 2'd0;
      end else if (dbusy) begin
        dph <= dph + 2'd1;
        if (dph == 2'd2) dbusy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind;
      y_r    <= year_offset;
      mon_r  <= month;
      dy_r   <= day;
      hr_r   <= hour;
      mi_r   <= minute;
      sc_r   <= second;
      cnt    <= seconds_in;
      yo     <= 7'd0;
      mo     <= 4'd1;
      oor    <= 1'b0;
      wd_q   <= 3'd0;
    end

    case (cmd.conv_op)
      escc_pkg::CV_DAYS:  acc <= {16'd0, days_calc};
      escc_pkg::CV_HOURS: acc <= 32'(acc * 32'd24) + {27'd0, hr_r};
      escc_pkg::CV_MINS:  acc <= 32'(acc * 32'd60) + {26'd0, mi_r};
      escc_pkg::CV_SECS:  cnt <= 32'(acc * 32'd60) + {26'd0, sc_r}
                               - {15'd0, escc_pkg::SECS_PER_DAY};
      default: ;
    endcase

    if (cmd.div_start) begin
      dvd  <= dividend;
      dsor <= divisor;
      djob <= cmd.div_job;
    end

    if (dbusy) begin
      case (dph)
        2'd0: dprod <= {26'd0, dmul_a} * {25'd0, dmul_b};
        2'd1: begin
          dq  <= dquo;
          dqd <= {16'd0, dquo} * {15'd0, dsor};
        end
        2'd2: begin
          case (djob)
            escc_pkg::JOB_DAY: begin
              days <= dq;
              rem  <= drem;
              oor  <= !kind_r && ({16'd0, dq} >= escc_pkg::DAYS_IN_RANGE);
            end
            escc_pkg::JOB_HOUR: begin
              hr_q <= dq[4:0];
              rem  <= drem;
            end
            escc_pkg::JOB_MIN: begin
              mi_q <= dq[5:0];
              sc_q <= drem[5:0];
            end
            default: wd_q <= drem[2:0];
          endcase
        end
        default: ;
      endcase
    end

    if (cmd.year_step && !year_fit) begin
      days <= days - {6'd0, year_len};
      yo   <= yo + 7'd1;
    end

    if (cmd.month_step && !month_fit) begin
      days <= days - {10'd0, mlen};
      mo   <= mo + 4'd1;
    end

    if (cmd.out_load) begin
      seconds_out     <= kind_r ? cnt : 32'd0;
      year_offset_out <= (!kind_r && !oor) ? yo : 7'd0;
      month_out       <= (!kind_r && !oor) ? mo : 4'd0;
      day_out         <= (!kind_r && !oor) ? (days[4:0] + 5'd1) : 5'd0;
      hour_out        <= kind_r ? 5'd0 : hr_q;
      minute_out      <= kind_r ? 6'd0 : mi_q;
      second_out      <= kind_r ? 6'd0 : sc_q;
      weekday         <= oor ? 3'd0 : wd_q;
      out_of_range    <= oor;
    end
  end

endmodule

// File: src/epoch_seconds_calendar_converter_core.sv
// epoch_seconds_calendar_converter_core: top level, seconds since 2000 <-> calendar date
// depends on escc_pkg, escc_ctrl and escc_dpath
//
//   channel | handshake          | payload
//   --------+--------------------+-----------------------------------------------
//   in      | in_valid, in_stall | kind, seconds_in, year_offset, month, day,
//           |                    | hour, minute, second
//   out     | out_valid,         | seconds_out, year_offset_out, month_out,
//           | out_stall          | day_out, hour_out, minute_out, second_out,
//           |                    | weekday, out_of_range
//
// one request at a time; each constant divide is a reciprocal multiply, then quotient times divisor,
// then remainder, framed by the sequencer's start and wait states; the year walk sets the pace
// date to seconds steps through setup, four multiply-add steps, two divides and finish;
// seconds to date runs four divides, then walks Y years (0 to 99) and M months (0 to 11),
// and finishes after three divides past 2099; the sequencer then returns to idle,
// where it takes the next transfer
// a new request is taken while a finished result still waits in the output register
// rst is synchronous; it clears the sequencer, the divider and the output valid
// a stalled result holds; the next result waits in the finish state until taken
`timescale 1ns / 1ps

module epoch_seconds_calendar_converter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [31:0] seconds_in,
  input  logic [6:0]  year_offset,
  input  logic [3:0]  month,
  input  logic [4:0]  day,
  input  logic [4:0]  hour,
  input  logic [5:0]  minute,
  input  logic [5:0]  second,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] seconds_out,
  output logic [6:0]  year_offset_out,
  output logic [3:0]  month_out,
  output logic [4:0]  day_out,
  output logic [4:0]  hour_out,
  output logic [5:0]  minute_out,
  output logic [5:0]  second_out,
  output logic [2:0]  weekday,
  output logic        out_of_range
);

  // command and status between sequencer and datapath
  escc_pkg::cmd_t  cmd;
  escc_pkg::stat_t stat;

  escc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  escc_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .kind            (kind),
    .seconds_in      (seconds_in),
    .year_offset     (year_offset),
    .month           (month),
    .day             (day),
    .hour            (hour),
    .minute          (minute),
    .second          (second),
    .seconds_out     (seconds_out),
    .year_offset_out (year_offset_out),
    .month_out       (month_out),
    .day_out         (day_out),
    .hour_out        (hour_out),
    .minute_out      (minute_out),
    .second_out      (second_out),
    .weekday         (weekday),
    .out_of_range    (out_of_range)
  );

  // a result past 2099 carries no date and no weekday
  a_oor_blank : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> year_offset_out == 7'd0 && month_out == 4'd0
                                  && day_out == 5'd0 && weekday == 3'd0)
    else $error("out_of_range result with date fields set");

  // weekday always lies in Sunday to Saturday
  a_weekday_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> weekday <= 3'd6)
    else $error("weekday beyond Saturday");

  // an accepted transfer occupies the sequencer
  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again straight after a transfer");

  // the divider only reports done while the sequencer waits on it
  a_done_busy : assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> in_stall && !cmd.out_load)
    else $error("divider done outside a conversion");

endmodule

// File: bench/tb_epoch_seconds_calendar_converter_core.sv
// testbench for epoch_seconds_calendar_converter_core: directed and random conversions
// both ways, each result checked against an in-bench calendar predictor
// depends only on the converter rtl
`timescale 1ns / 1ps

module tb_epoch_seconds_calendar_converter_core;

  localparam logic KIND_TO_DATE    = 1'b0;
  localparam logic KIND_TO_SECONDS = 1'b1;

  localparam int unsigned DAY_SECS     = 86400;
  localparam int unsigned SPAN_DAYS    = 36525;
  localparam logic [31:0] LAST_IN_SPAN = 32'd3155759999;
  localparam int          SETTLE_CYCLES = 300;

  typedef struct packed {
    logic        kind;
    logic [31:0] secs;
    logic [6:0]  yoff;
    logic [3:0]  mon;
    logic [4:0]  mday;
    logic [4:0]  hh;
    logic [5:0]  mm;
    logic [5:0]  ss;
  } conv_req_t;

  typedef struct packed {
    logic [31:0] secs;
    logic [6:0]  yoff;
    logic [3:0]  mon;
    logic [4:0]  mday;
    logic [4:0]  hh;
    logic [5:0]  mm;
    logic [5:0]  ss;
    logic [2:0]  wday;
    logic        oor;
  } conv_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = 1'b0;
  logic [31:0] seconds_in = '0;
  logic [6:0]  year_offset = '0;
  logic [3:0]  month = '0;
  logic [4:0]  day = '0;
  logic [4:0]  hour = '0;
  logic [5:0]  minute = '0;
  logic [5:0]  second = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] seconds_out;
  logic [6:0]  year_offset_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic [4:0]  hour_out;
  logic [5:0]  minute_out;
  logic [5:0]  second_out;
  logic [2:0]  weekday;
  logic        out_of_range;

  conv_res_t pending_results[$];
  int        error_count = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;

  epoch_seconds_calendar_converter_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .seconds_in(seconds_in), .year_offset(year_offset),
    .month(month), .day(day), .hour(hour), .minute(minute), .second(second),
    .out_valid(out_valid), .out_stall(out_stall),
    .seconds_out(seconds_out), .year_offset_out(year_offset_out),
    .month_out(month_out), .day_out(day_out), .hour_out(hour_out),
    .minute_out(minute_out), .second_out(second_out),
    .weekday(weekday), .out_of_range(out_of_range)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned month_days(input int unsigned m);
    case (m)
      2:       return 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic logic [31:0] calendar_to_count(input int unsigned y, input int unsigned mo,
                                                    input int unsigned d, input int unsigned h,
                                                    input int unsigned mi, input int unsigned s);
    logic [63:0] days;
    logic [63:0] total;
    days = 64'(d);
    for (int unsigned i = 1; i < mo && i <= 12; i++) days += 64'(month_days(i));
    if (mo > 2 && (y % 4) == 0) days += 64'd1;
    days += 64'(365 * y) + 64'((y + 3) / 4);
    total = ((days * 24 + h) * 60 + mi) * 60 + s;
    total -= DAY_SECS;
    return total[31:0];
  endfunction

  function automatic logic [2:0] weekday_of(input logic [31:0] count);
    return 3'((count / DAY_SECS + 6) % 7);
  endfunction

  function automatic conv_res_t predict_conversion(input conv_req_t r);
    conv_res_t   res;
    int unsigned days;
    int unsigned rem;
    int unsigned yo;
    int unsigned mo;
    int unsigned leap;
    int unsigned len;
    res = '0;
    if (r.kind == KIND_TO_SECONDS) begin
      res.secs = calendar_to_count(32'(r.yoff), 32'(r.mon), 32'(r.mday), 32'(r.hh),
                                   32'(r.mm), 32'(r.ss));
      res.wday = weekday_of(res.secs);
      return res;
    end
    days    = r.secs / DAY_SECS;
    rem     = r.secs % DAY_SECS;
    res.hh  = 5'(rem / 3600);
    res.mm  = 6'((rem / 60) % 60);
    res.ss  = 6'(rem % 60);
    if (days >= SPAN_DAYS) begin
      res.oor = 1'b1;
      return res;
    end
    yo = 0;
    forever begin
      leap = (yo % 4 == 0) ? 1 : 0;
      if (days < 365 + leap) break;
      days -= 365 + leap;
      yo++;
    end
    for (mo = 1; mo < 12; mo++) begin
      len = month_days(mo) + ((leap != 0 && mo == 2) ? 1 : 0);
      if (days < len) break;
      days -= len;
    end
    res.yoff = 7'(yo);
    res.mon  = 4'(mo);
    res.mday = 5'(days + 1);
    res.wday = weekday_of(r.secs);
    return res;
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic send_item(input conv_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= r.kind;
    seconds_in  <= r.secs;
    year_offset <= r.yoff;
    month       <= r.mon;
    day         <= r.mday;
    hour        <= r.hh;
    minute      <= r.mm;
    second      <= r.ss;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_conversion(r));
  endtask

  // sender holds off until every outstanding result has been taken
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // unused fields get random content so they are shown to be ignored
  function automatic conv_req_t date_request(input int unsigned y, input int unsigned mo,
                                             input int unsigned d, input int unsigned h,
                                             input int unsigned mi, input int unsigned s);
    conv_req_t r;
    r.kind = KIND_TO_SECONDS;
    r.secs = $urandom;
    r.yoff = 7'(y);
    r.mon  = 4'(mo);
    r.mday = 5'(d);
    r.hh   = 5'(h);
    r.mm   = 6'(mi);
    r.ss   = 6'(s);
    return r;
  endfunction

  function automatic conv_req_t count_request(input logic [31:0] count);
    conv_req_t r;
    r      = conv_req_t'({$urandom, $urandom});
    r.kind = KIND_TO_DATE;
    r.secs = count;
    return r;
  endfunction

  function automatic conv_req_t random_request();
    int unsigned y;
    int unsigned mo;
    int unsigned pick;
    pick = $urandom_range(99);
    y    = $urandom_range(99);
    mo   = $urandom_range(12, 1);
    if ($urandom_range(1) == 1) begin
      if (pick < 85)
        return date_request(y, mo,
                            $urandom_range(month_days(mo) + ((mo == 2 && y % 4 == 0) ? 1 : 0), 1),
                            $urandom_range(23), $urandom_range(59), $urandom_range(59));
      // fields outside their stated ranges
      return date_request($urandom_range(127), $urandom_range(15), $urandom_range(31),
                          $urandom_range(31), $urandom_range(63), $urandom_range(63));
    end
    if (pick < 70) return count_request($urandom_range(LAST_IN_SPAN, 0));
    if (pick < 85) // close to a month or year boundary
      return count_request(calendar_to_count(y, mo, 1, 0, 0, 0) + $urandom_range(3) - 2);
    if (pick < 93) return count_request($urandom_range(32'hFFFF_FFFF, LAST_IN_SPAN + 1));
    return count_request($urandom);
  endfunction

  // ---------------------------------------------------------------- receiving

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : check_result
    conv_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("seconds_out", want.secs, seconds_out);
        compare_field("year_offset_out", 32'(want.yoff), 32'(year_offset_out));
        compare_field("month_out", 32'(want.mon), 32'(month_out));
        compare_field("day_out", 32'(want.mday), 32'(day_out));
        compare_field("hour_out", 32'(want.hh), 32'(hour_out));
        compare_field("minute_out", 32'(want.mm), 32'(minute_out));
        compare_field("second_out", 32'(want.ss), 32'(second_out));
        compare_field("weekday", 32'(want.wday), 32'(weekday));
        compare_field("out_of_range", 32'(want.oor), 32'(out_of_range));
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_date_to_seconds();
    send_item(date_request(0, 1, 1, 0, 0, 0));       // epoch itself
    send_item(date_request(99, 12, 31, 23, 59, 59)); // last second of the span
    send_item(date_request(0, 1, 0, 0, 0, 0));       // day zero at the epoch wraps
    send_item(date_request(5, 0, 10, 6, 7, 8));      // month zero
    send_item(date_request(7, 1, 15, 1, 2, 3));      // january, no earlier months
    send_item(date_request(3, 13, 31, 12, 0, 0));    // month past twelve
    send_item(date_request(24, 2, 29, 23, 59, 59));  // leap day
    send_item(date_request(24, 3, 1, 0, 0, 0));      // after a leap february
    send_item(date_request(68, 6, 15, 12, 30, 45));  // past the signed overflow
    send_item(date_request(127, 15, 31, 31, 63, 63)); // every field bit set
    wait_for_drain();
  endtask

  task automatic test_seconds_to_date();
    send_item(count_request(32'd0));
    send_item(count_request(32'd86399));
    send_item(count_request(32'd5097599));   // end of 28 february 2000
    send_item(count_request(32'd5097600));   // leap day 2000
    send_item(count_request(32'd31622399));  // end of leap year 2000
    send_item(count_request(32'd31622400));  // first day of 2001
    send_item(count_request(32'h8000_0000)); // signed overflow point
    send_item(count_request(LAST_IN_SPAN));
    send_item(count_request(LAST_IN_SPAN + 1)); // first count past 2099
    send_item(count_request(32'hFFFF_FFFF));
    wait_for_drain();
  endtask

  task automatic test_random_traffic(input int n_items, input int idle_pct,
                                     input int rx_stall_pct);
    send_idle_pct = idle_pct;
    stall_pct     = rx_stall_pct;
    for (int i = 0; i < n_items; i++) begin
      send_item(random_request());
      if (i % 97 == 96) wait_for_drain();
    end
    wait_for_drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_date_to_seconds();
    test_seconds_to_date();
    test_random_traffic(350, 26, 56);
    test_random_traffic(350, 56, 26);
    test_random_traffic(350, 0, 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule
